// File: hw/rtl/jtt_pkg.sv
// ----------------------------------------------------------------------------
// Journal transaction tracker package
// Shared widths, codes and types for the redo-log transaction tracker.
// ----------------------------------------------------------------------------
package jtt_pkg;

   // Number of block slots in the transaction table.
   localparam int LOG_ENTRIES = 16;
   localparam int TBL_AW      = (LOG_ENTRIES > 1) ? $clog2(LOG_ENTRIES) : 1;
   localparam int TBL_CW      = $clog2(LOG_ENTRIES + 1);

   // Fixed field widths of the channels and registers.
   localparam int KIND_W   = 2;
   localparam int BLOCK_W  = 32;
   localparam int STATUS_W = 4;
   localparam int INDEX_W  = 4;
   localparam int COUNT_W  = 5;
   localparam int OPS_W    = 5;
   localparam int AREA_W   = 16;
   localparam int RSV_W    = 5;
   localparam int CSR_IW   = 2;
   localparam int CSR_DW   = 32;

   // Request kinds.
   localparam logic [KIND_W-1:0] KIND_BEGIN = 2'd0;
   localparam logic [KIND_W-1:0] KIND_END   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_WRITE = 2'd2;

   // Register indexes.
   localparam logic [CSR_IW-1:0] CSR_LOG_START     = 2'd0;
   localparam logic [CSR_IW-1:0] CSR_LOG_AREA      = 2'd1;
   localparam logic [CSR_IW-1:0] CSR_MAX_OP_BLOCKS = 2'd2;

   typedef enum logic [STATUS_W-1:0] {
      ST_GRANTED    = 4'd0,
      ST_WAIT       = 4'd1,
      ST_ENDED      = 4'd2,
      ST_ABSORBED   = 4'd3,
      ST_APPENDED   = 4'd4,
      ST_COPY       = 4'd5,
      ST_HDR_ENTRY  = 4'd6,
      ST_HDR_WRITE  = 4'd7,
      ST_TOO_BIG    = 4'd8,
      ST_OUTSIDE    = 4'd9,
      ST_UNMATCHED  = 4'd10
   } status_type;

   typedef struct packed {
      logic [BLOCK_W-1:0] log_start;
      logic [AREA_W-1:0]  log_area_blocks;
      logic [RSV_W-1:0]   max_op_blocks;
   } cfg_type;

   typedef struct packed {
      logic               rd_en;
      logic [TBL_AW-1:0]  rd_addr;
      logic               wr_en;
      logic [TBL_AW-1:0]  wr_addr;
      logic [BLOCK_W-1:0] wr_data;
   } tbl_req_type;

endpackage

// File: hw/rtl/jtt_intf.sv
// ----------------------------------------------------------------------------
// Journal transaction tracker channels
// Valid/ready channels for request beats and response beats.
// ----------------------------------------------------------------------------
interface jtt_req_if import jtt_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [KIND_W-1:0]  kind;
   logic [BLOCK_W-1:0] block_number;

   modport source (output valid, output kind, output block_number, input ready);
   modport sink   (input valid, input kind, input block_number, output ready);
endinterface

interface jtt_rsp_if import jtt_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [BLOCK_W-1:0]  src_block;
   logic [BLOCK_W-1:0]  dst_block;
   logic [INDEX_W-1:0]  entry_index;
   logic [COUNT_W-1:0]  entry_count;
   logic                last;

   modport source (output valid, output status, output src_block, output dst_block,
                   output entry_index, output entry_count, output last, input ready);
   modport sink   (input valid, input status, input src_block, input dst_block,
                   input entry_index, input entry_count, input last, output ready);
endinterface

// File: hw/rtl/jtt_table.sv
// ----------------------------------------------------------------------------
// Journal transaction table
// Single-port-write, single-port-read block table with registered read data.
// ----------------------------------------------------------------------------
module jtt_table import jtt_pkg::*; (
   input  logic               clock,
   input  tbl_req_type        tbl_req,
   output logic [BLOCK_W-1:0] rd_data
);

   logic [BLOCK_W-1:0] mem [LOG_ENTRIES];
   logic [BLOCK_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (tbl_req.wr_en) begin
         mem[tbl_req.wr_addr] <= tbl_req.wr_data;
      end
   end

   // Read data holds until the next read, so a stalled command keeps its operand.
   always_ff @(posedge clock) begin
      if (tbl_req.rd_en) begin
         rd_data_ff <= mem[tbl_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/jtt_seq.sv
// ----------------------------------------------------------------------------
// Journal transaction sequencer
// Admission, table search and append, and the commit command sequence.
// ----------------------------------------------------------------------------
module jtt_seq import jtt_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   jtt_req_if.sink            req,
   jtt_rsp_if.source          rsp,
   input  cfg_type            cfg,
   output tbl_req_type        tbl_req,
   input  logic [BLOCK_W-1:0] tbl_rd_data
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SEND,
      S_SEARCH,
      S_CREAD,
      S_CEMIT,
      S_HDR_SET,
      S_HDR_CLR
   } state_type;

   typedef enum logic [1:0] {
      PH_COPY,
      PH_ENTRY,
      PH_INSTALL
   } phase_type;

   state_type           state_ff, state_in;
   phase_type           phase_ff, phase_in;
   logic [TBL_CW-1:0]   count_ff, count_in;
   logic [OPS_W-1:0]    ops_ff, ops_in;
   logic [BLOCK_W-1:0]  blk_ff, blk_in;
   logic [TBL_CW-1:0]   ptr_ff, ptr_in;
   logic                cmp_vld_ff, cmp_vld_in;
   logic [TBL_AW-1:0]   cmp_idx_ff, cmp_idx_in;
   status_type          pend_status_ff, pend_status_in;
   logic [TBL_AW-1:0]   pend_idx_ff, pend_idx_in;
   logic [TBL_CW-1:0]   pend_cnt_ff, pend_cnt_in;

   logic                rsp_vld_ff, rsp_vld_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [BLOCK_W-1:0]  rsp_src_ff, rsp_src_in;
   logic [BLOCK_W-1:0]  rsp_dst_ff, rsp_dst_in;
   logic [INDEX_W-1:0]  rsp_idx_ff, rsp_idx_in;
   logic [COUNT_W-1:0]  rsp_cnt_ff, rsp_cnt_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                slot_free;
   logic [OPS_W:0]      ops_plus;
   logic [10:0]         reserve;
   logic [11:0]         need;
   logic                too_big;
   logic [BLOCK_W-1:0]  log_blk;
   logic                ptr_at_end;

   assign slot_free  = !rsp_vld_ff || rsp.ready;
   assign ops_plus   = {1'b0, ops_ff} + (OPS_W+1)'(1);
   assign reserve    = 11'(ops_plus) * 11'(cfg.max_op_blocks);
   assign need       = 12'(reserve) + 12'(count_ff);
   assign too_big    = (count_ff >= TBL_CW'(LOG_ENTRIES)) ||
                       ((17'(count_ff) + 17'd1) >= 17'(cfg.log_area_blocks));
   assign log_blk    = cfg.log_start + BLOCK_W'(ptr_ff) + BLOCK_W'(1);
   assign ptr_at_end = (ptr_ff + TBL_CW'(1)) == count_ff;

   assign req.ready       = (state_ff == S_IDLE);
   assign rsp.valid       = rsp_vld_ff;
   assign rsp.status      = rsp_status_ff;
   assign rsp.src_block   = rsp_src_ff;
   assign rsp.dst_block   = rsp_dst_ff;
   assign rsp.entry_index = rsp_idx_ff;
   assign rsp.entry_count = rsp_cnt_ff;
   assign rsp.last        = rsp_last_ff;

   always_comb begin
      state_in       = state_ff;
      phase_in       = phase_ff;
      count_in       = count_ff;
      ops_in         = ops_ff;
      blk_in         = blk_ff;
      ptr_in         = ptr_ff;
      cmp_vld_in     = 1'b0;
      cmp_idx_in     = cmp_idx_ff;
      pend_status_in = pend_status_ff;
      pend_idx_in    = pend_idx_ff;
      pend_cnt_in    = pend_cnt_ff;
      rsp_vld_in     = rsp_vld_ff && !rsp.ready;
      rsp_status_in  = rsp_status_ff;
      rsp_src_in     = rsp_src_ff;
      rsp_dst_in     = rsp_dst_ff;
      rsp_idx_in     = rsp_idx_ff;
      rsp_cnt_in     = rsp_cnt_ff;
      rsp_last_in    = rsp_last_ff;
      tbl_req        = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               blk_in      = req.block_number;
               ptr_in      = '0;
               pend_idx_in = '0;
               pend_cnt_in = count_ff;
               case (req.kind)
                  KIND_BEGIN: begin
                     if ((&ops_ff) || (need > 12'(LOG_ENTRIES))) begin
                        pend_status_in = ST_WAIT;
                     end else begin
                        pend_status_in = ST_GRANTED;
                        ops_in         = ops_plus[OPS_W-1:0];
                     end
                     state_in = S_SEND;
                  end
                  KIND_END: begin
                     if (ops_ff == '0) begin
                        pend_status_in = ST_UNMATCHED;
                        state_in       = S_SEND;
                     end else begin
                        ops_in = ops_ff - OPS_W'(1);
                        if ((ops_ff == OPS_W'(1)) && (count_ff != '0)) begin
                           phase_in = PH_COPY;
                           state_in = S_CREAD;
                        end else begin
                           pend_status_in = ST_ENDED;
                           state_in       = S_SEND;
                        end
                     end
                  end
                  KIND_WRITE: begin
                     if (too_big) begin
                        pend_status_in = ST_TOO_BIG;
                        state_in       = S_SEND;
                     end else if (ops_ff == '0) begin
                        pend_status_in = ST_OUTSIDE;
                        state_in       = S_SEND;
                     end else begin
                        state_in = S_SEARCH;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end

         S_SEND: begin
            if (slot_free) begin
               rsp_vld_in    = 1'b1;
               rsp_status_in = pend_status_ff;
               rsp_src_in    = '0;
               rsp_dst_in    = '0;
               rsp_idx_in    = INDEX_W'(pend_idx_ff);
               rsp_cnt_in    = COUNT_W'(pend_cnt_ff);
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end

         // One table read issued per cycle; its data is compared on the next cycle.
         S_SEARCH: begin
            if (cmp_vld_ff && (tbl_rd_data == blk_ff)) begin
               pend_status_in = ST_ABSORBED;
               pend_idx_in    = cmp_idx_ff;
               pend_cnt_in    = count_ff;
               state_in       = S_SEND;
            end else if (ptr_ff == count_ff) begin
               tbl_req.wr_en   = 1'b1;
               tbl_req.wr_addr = count_ff[TBL_AW-1:0];
               tbl_req.wr_data = blk_ff;
               pend_status_in  = ST_APPENDED;
               pend_idx_in     = count_ff[TBL_AW-1:0];
               pend_cnt_in     = count_ff + TBL_CW'(1);
               count_in        = count_ff + TBL_CW'(1);
               state_in        = S_SEND;
            end else begin
               tbl_req.rd_en   = 1'b1;
               tbl_req.rd_addr = ptr_ff[TBL_AW-1:0];
               cmp_vld_in      = 1'b1;
               cmp_idx_in      = ptr_ff[TBL_AW-1:0];
               ptr_in          = ptr_ff + TBL_CW'(1);
            end
         end

         S_CREAD: begin
            tbl_req.rd_en   = 1'b1;
            tbl_req.rd_addr = ptr_ff[TBL_AW-1:0];
            state_in        = S_CEMIT;
         end

         S_CEMIT: begin
            if (slot_free) begin
               rsp_vld_in  = 1'b1;
               rsp_idx_in  = INDEX_W'(ptr_ff);
               rsp_last_in = 1'b0;
               unique case (phase_ff)
                  PH_COPY: begin
                     rsp_status_in = ST_COPY;
                     rsp_src_in    = tbl_rd_data;
                     rsp_dst_in    = log_blk;
                     rsp_cnt_in    = COUNT_W'(count_ff);
                  end
                  PH_ENTRY: begin
                     rsp_status_in = ST_HDR_ENTRY;
                     rsp_src_in    = '0;
                     rsp_dst_in    = tbl_rd_data;
                     rsp_cnt_in    = COUNT_W'(count_ff);
                  end
                  default: begin
                     rsp_status_in = ST_COPY;
                     rsp_src_in    = log_blk;
                     rsp_dst_in    = tbl_rd_data;
                     rsp_cnt_in    = '0;
                  end
               endcase
               if (ptr_at_end) begin
                  ptr_in = '0;
                  unique case (phase_ff)
                     PH_COPY: begin
                        phase_in = PH_ENTRY;
                        state_in = S_CREAD;
                     end
                     PH_ENTRY: begin
                        state_in = S_HDR_SET;
                     end
                     default: begin
                        state_in = S_HDR_CLR;
                     end
                  endcase
               end else begin
                  ptr_in   = ptr_ff + TBL_CW'(1);
                  state_in = S_CREAD;
               end
            end
         end

         S_HDR_SET: begin
            if (slot_free) begin
               rsp_vld_in    = 1'b1;
               rsp_status_in = ST_HDR_WRITE;
               rsp_src_in    = '0;
               rsp_dst_in    = cfg.log_start;
               rsp_idx_in    = '0;
               rsp_cnt_in    = COUNT_W'(count_ff);
               rsp_last_in   = 1'b0;
               phase_in      = PH_INSTALL;
               ptr_in        = '0;
               state_in      = S_CREAD;
            end
         end

         S_HDR_CLR: begin
            if (slot_free) begin
               rsp_vld_in    = 1'b1;
               rsp_status_in = ST_HDR_WRITE;
               rsp_src_in    = '0;
               rsp_dst_in    = cfg.log_start;
               rsp_idx_in    = '0;
               rsp_cnt_in    = '0;
               rsp_last_in   = 1'b1;
               count_in      = '0;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         count_ff   <= '0;
         ops_ff     <= '0;
         rsp_vld_ff <= 1'b0;
         cmp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         ops_ff     <= ops_in;
         rsp_vld_ff <= rsp_vld_in;
         cmp_vld_ff <= cmp_vld_in;
      end
      phase_ff       <= phase_in;
      blk_ff         <= blk_in;
      ptr_ff         <= ptr_in;
      cmp_idx_ff     <= cmp_idx_in;
      pend_status_ff <= pend_status_in;
      pend_idx_ff    <= pend_idx_in;
      pend_cnt_ff    <= pend_cnt_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_src_ff     <= rsp_src_in;
      rsp_dst_ff     <= rsp_dst_in;
      rsp_idx_ff     <= rsp_idx_in;
      rsp_cnt_ff     <= rsp_cnt_in;
      rsp_last_ff    <= rsp_last_in;
   end

endmodule

// File: hw/rtl/journal_transaction_tracker.sv
// ----------------------------------------------------------------------------
// Journal transaction tracker
// Redo-log transaction tracker for one device, with block absorption.
// ----------------------------------------------------------------------------
// The tracker takes one request beat at a time and answers with one or more
// response beats, the final one flagged by last. A begin, an end that does
// not commit, or a refused write goes from the idle state to the send state,
// which registers its single response beat. An accepted write scans the
// block table through its single read port, one entry per cycle, until it
// finds the block or appends it. A committing end reads the table once per
// copy or header entry, emitting each of those 3n beats for n logged blocks
// after its read, and adds the two header writes. A busy response sink stalls
// these sequences; the next request is taken as soon as the last response
// beat sits in the output register.
module journal_transaction_tracker import jtt_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   jtt_req_if.sink           req,
   jtt_rsp_if.source         rsp,
   input  logic              csr_wr_en,
   input  logic [CSR_IW-1:0] csr_index,
   input  logic [CSR_DW-1:0] csr_data
);

   cfg_type            cfg_ff;
   cfg_type            cfg_in;
   tbl_req_type        tbl_req;
   logic [BLOCK_W-1:0] tbl_rd_data;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_LOG_START:     cfg_in.log_start       = csr_data[BLOCK_W-1:0];
            CSR_LOG_AREA:      cfg_in.log_area_blocks = csr_data[AREA_W-1:0];
            CSR_MAX_OP_BLOCKS: cfg_in.max_op_blocks   = csr_data[RSV_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.log_start       <= BLOCK_W'(2);
         cfg_ff.log_area_blocks <= AREA_W'(17);
         cfg_ff.max_op_blocks   <= RSV_W'(4);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   jtt_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .req         (req),
      .rsp         (rsp),
      .cfg         (cfg_ff),
      .tbl_req     (tbl_req),
      .tbl_rd_data (tbl_rd_data)
   );

   jtt_table u_table (
      .clock   (clock),
      .tbl_req (tbl_req),
      .rd_data (tbl_rd_data)
   );

endmodule

// File: tb/journal_transaction_tracker_tb.sv
// ----------------------------------------------------------------------------
// Journal transaction tracker testbench
// Drives begin, end and write request beats into the tracker under random
// idling on both channels. Reprograms the log registers between transactions,
// including their extremes. Each response beat is checked field by field
// against a directed row's expectation or a transaction model kept inside this bench.
// ----------------------------------------------------------------------------
module journal_transaction_tracker_tb;
   import jtt_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [KIND_W-1:0] KIND_UNKNOWN = 2'd3;
   localparam int ITEM_TARGET      = 130;
   localparam int SETTLE_CYCLES    = 8;
   localparam int TAIL_CYCLES      = 30;
   localparam int WATCHDOG_LIMIT   = 4000;
   localparam int SATURATION_PHASE = 2;
   localparam int OPS_CEILING      = 31;
   localparam int POOL_SIZE        = 8;

   typedef struct packed {
      status_type         status;
      logic [BLOCK_W-1:0] src_block;
      logic [BLOCK_W-1:0] dst_block;
      logic [INDEX_W-1:0] entry_index;
      logic [COUNT_W-1:0] entry_count;
      logic               last;
   } journal_beat_type;

   // A row either writes one register or sends one request beat.
   typedef struct packed {
      logic               is_csr;
      logic [1:0]         code;
      logic [BLOCK_W-1:0] value;
      logic               typed;
      status_type         status;
      logic [COUNT_W-1:0] count;
   } stim_row_type;

   localparam int DIRECTED_ROWS = 27;

   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{1'b0, KIND_END,          32'h0000_0000, 1'b1, ST_UNMATCHED, 5'd0},
      '{1'b0, KIND_WRITE,        32'h1234_5678, 1'b1, ST_OUTSIDE,   5'd0},
      '{1'b0, KIND_UNKNOWN,      32'hFFFF_FFFF, 1'b0, ST_GRANTED,   5'd0},
      '{1'b0, KIND_BEGIN,        32'h0000_0000, 1'b1, ST_GRANTED,   5'd0},
      '{1'b0, KIND_WRITE,        32'h0000_0000, 1'b0, ST_GRANTED,   5'd0},
      '{1'b0, KIND_WRITE,        32'hFFFF_FFFF, 1'b0, ST_GRANTED,   5'd0},
      '{1'b0, KIND_WRITE,        32'h0000_0000, 1'b0, ST_GRANTED,   5'd0},
      '{1'b0, KIND_BEGIN,        32'h0000_0000, 1'b1, ST_GRANTED,   5'd2},
      '{1'b0, KIND_BEGIN,        32'hFFFF_FFFF, 1'b1, ST_GRANTED,   5'd2},
      '{1'b0, KIND_BEGIN,        32'h0000_0000, 1'b1, ST_WAIT,      5'd2},
      '{1'b0, KIND_END,          32'h0000_0000, 1'b1, ST_ENDED,     5'd2},
      '{1'b0, KIND_END,          32'h0000_0000, 1'b1, ST_ENDED,     5'd2},
      '{1'b0, KIND_WRITE,        32'hA5A5_A5A5, 1'b0, ST_GRANTED,   5'd0},
      '{1'b0, KIND_END,          32'h0000_0000, 1'b0, ST_GRANTED,   5'd0},
      '{1'b0, KIND_END,          32'h0000_0000, 1'b1, ST_UNMATCHED, 5'd0},
      '{1'b0, KIND_BEGIN,        32'h0000_0000, 1'b1, ST_GRANTED,   5'd0},
      '{1'b0, KIND_END,          32'h0000_0000, 1'b1, ST_ENDED,     5'd0},
      '{1'b1, CSR_LOG_AREA,      32'd2,         1'b0, ST_GRANTED,   5'd0},
      '{1'b1, CSR_LOG_START,     32'hFFFF_FFFF, 1'b0, ST_GRANTED,   5'd0},
      '{1'b0, KIND_BEGIN,        32'h0000_0000, 1'b1, ST_GRANTED,   5'd0},
      '{1'b0, KIND_WRITE,        32'h5A5A_5A5A, 1'b0, ST_GRANTED,   5'd0},
      '{1'b0, KIND_WRITE,        32'h0000_0000, 1'b1, ST_TOO_BIG,   5'd1},
      '{1'b0, KIND_END,          32'h0000_0000, 1'b0, ST_GRANTED,   5'd0},
      '{1'b1, CSR_MAX_OP_BLOCKS, 32'd16,        1'b0, ST_GRANTED,   5'd0},
      '{1'b0, KIND_BEGIN,        32'h0000_0000, 1'b1, ST_GRANTED,   5'd0},
      '{1'b0, KIND_BEGIN,        32'h0000_0000, 1'b1, ST_WAIT,      5'd0},
      '{1'b0, KIND_END,          32'h0000_0000, 1'b1, ST_ENDED,     5'd0}
   };

   logic              clock = 1'b0;
   logic              reset;
   logic              csr_wr_en;
   logic [CSR_IW-1:0] csr_index;
   logic [CSR_DW-1:0] csr_data;

   jtt_req_if req_ch ();
   jtt_rsp_if rsp_ch ();

   journal_transaction_tracker dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // Model of the tracker: registers, block table and open operations.
   logic [BLOCK_W-1:0] cfg_log_start;
   int                 cfg_area;
   int                 cfg_reserve;
   logic [BLOCK_W-1:0] jnl_blocks [LOG_ENTRIES];
   int                 jnl_count;
   int                 open_ops;

   journal_beat_type item_beats [$];
   journal_beat_type journal_beats_due [$];
   logic [BLOCK_W-1:0] block_pool [POOL_SIZE];

   int  mismatches = 0;
   int  quiet_cycles = 0;
   int  items_sent;
   bit  no_idle;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void stage_beat(status_type st, logic [BLOCK_W-1:0] src,
                                      logic [BLOCK_W-1:0] dst, int idx, int cnt);
      item_beats.push_back('{st, src, dst, INDEX_W'(idx), COUNT_W'(cnt), 1'b0});
   endfunction

   function automatic void track_journal(logic [KIND_W-1:0] kind, logic [BLOCK_W-1:0] blk);
      int need;
      int slot;
      int n;
      item_beats.delete();
      case (kind)
         KIND_BEGIN: begin
            need = jnl_count + (open_ops + 1) * cfg_reserve;
            if (open_ops >= OPS_CEILING || need > LOG_ENTRIES) begin
               stage_beat(ST_WAIT, '0, '0, 0, jnl_count);
            end else begin
               open_ops++;
               stage_beat(ST_GRANTED, '0, '0, 0, jnl_count);
            end
         end
         KIND_END: begin
            if (open_ops == 0) begin
               stage_beat(ST_UNMATCHED, '0, '0, 0, jnl_count);
            end else begin
               open_ops--;
               if (open_ops == 0 && jnl_count > 0) begin
                  n = jnl_count;
                  for (int i = 0; i < n; i++)
                     stage_beat(ST_COPY, jnl_blocks[i], cfg_log_start + BLOCK_W'(i + 1), i, n);
                  for (int i = 0; i < n; i++)
                     stage_beat(ST_HDR_ENTRY, '0, jnl_blocks[i], i, n);
                  stage_beat(ST_HDR_WRITE, '0, cfg_log_start, 0, n);
                  for (int i = 0; i < n; i++)
                     stage_beat(ST_COPY, cfg_log_start + BLOCK_W'(i + 1), jnl_blocks[i], i, 0);
                  stage_beat(ST_HDR_WRITE, '0, cfg_log_start, 0, 0);
                  jnl_count = 0;
               end else begin
                  stage_beat(ST_ENDED, '0, '0, 0, jnl_count);
               end
            end
         end
         KIND_WRITE: begin
            if (jnl_count >= LOG_ENTRIES || jnl_count + 1 >= cfg_area) begin
               stage_beat(ST_TOO_BIG, '0, '0, 0, jnl_count);
            end else if (open_ops == 0) begin
               stage_beat(ST_OUTSIDE, '0, '0, 0, jnl_count);
            end else begin
               slot = jnl_count;
               for (int i = 0; i < jnl_count; i++)
                  if (slot == jnl_count && jnl_blocks[i] == blk)
                     slot = i;
               if (slot < jnl_count) begin
                  stage_beat(ST_ABSORBED, '0, '0, slot, jnl_count);
               end else begin
                  jnl_blocks[slot] = blk;
                  jnl_count++;
                  stage_beat(ST_APPENDED, '0, '0, slot, jnl_count);
               end
            end
         end
         default: ;
      endcase
      if (item_beats.size() != 0)
         item_beats[item_beats.size() - 1].last = 1'b1;
   endfunction

   // Holds valid until the beat is taken; a gap lowers it for whole cycles.
   task automatic send_request(logic [KIND_W-1:0] kind, logic [BLOCK_W-1:0] blk,
                               logic typed, status_type st, logic [COUNT_W-1:0] cnt);
      while (!no_idle && $urandom_range(0, 99) < 37) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.kind         <= kind;
      req_ch.block_number <= blk;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
      track_journal(kind, blk);
      if (typed)
         journal_beats_due.push_back('{st, '0, '0, '0, cnt, 1'b1});
      else
         foreach (item_beats[i])
            journal_beats_due.push_back(item_beats[i]);
      if (kind != KIND_UNKNOWN)
         items_sent++;
   endtask

   // An unknown kind leaves no response, so a few extra cycles cover it.
   task automatic settle_block();
      req_ch.valid <= 1'b0;
      while (journal_beats_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(logic [CSR_IW-1:0] idx, logic [CSR_DW-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_LOG_START:     cfg_log_start = data;
         CSR_LOG_AREA:      cfg_area      = int'(data[AREA_W-1:0]);
         CSR_MAX_OP_BLOCKS: cfg_reserve   = int'(data[RSV_W-1:0]);
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic program_phase(int phase);
      logic [BLOCK_W-1:0] start;
      logic [AREA_W-1:0]  area;
      logic [RSV_W-1:0]   reserve;
      start = $urandom();
      area  = ($urandom_range(0, 99) < 80) ? AREA_W'($urandom_range(2, 20))
                                            : AREA_W'($urandom_range(21, 65535));
      reserve = ($urandom_range(0, 9) == 0) ? RSV_W'(16) : RSV_W'($urandom_range(1, 8));
      case (phase)
         0: begin start = 32'hFFFF_FFF0; area = 16'hFFFF; reserve = 5'd1; end
         1: begin start = 32'h0000_0000; area = 16'd5;    reserve = 5'd3; end
         SATURATION_PHASE: begin area = 16'd17; reserve = 5'd0; end
         3: begin area = 16'd1; reserve = 5'd2; end
         4: begin area = 16'd0; reserve = 5'd16; end
         default: ;
      endcase
      foreach (block_pool[i])
         block_pool[i] = $urandom();
      settle_block();
      write_register(CSR_LOG_START, start);
      write_register(CSR_LOG_AREA, CSR_DW'(area));
      write_register(CSR_MAX_OP_BLOCKS, CSR_DW'(reserve));
   endtask

   // Mostly well-formed traffic for the current state, with some noise.
   task automatic send_random_request();
      logic [KIND_W-1:0]  kind;
      logic [BLOCK_W-1:0] blk;
      int r;
      r = $urandom_range(0, 99);
      if (open_ops == 0)
         kind = (r < 60) ? KIND_BEGIN : (r < 72) ? KIND_WRITE :
                (r < 84) ? KIND_END : KIND_UNKNOWN;
      else
         kind = (r < 62) ? KIND_WRITE : (r < 80) ? KIND_END :
                (r < 94) ? KIND_BEGIN : KIND_UNKNOWN;
      r = $urandom_range(0, 99);
      if (r < 50)
         blk = block_pool[$urandom_range(0, POOL_SIZE - 1)];
      else if (r < 56)
         blk = 32'h0000_0000;
      else if (r < 62)
         blk = 32'hFFFF_FFFF;
      else
         blk = $urandom();
      send_request(kind, blk, 1'b0, ST_GRANTED, '0);
   endtask

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      journal_beat_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (journal_beats_due.size() == 0) begin
            $error("response beat with status %0d arrived with nothing expected",
                   rsp_ch.status);
            mismatches++;
         end else begin
            want = journal_beats_due.pop_front();
            check_field("status", 32'(want.status), 32'(rsp_ch.status));
            check_field("src_block", want.src_block, rsp_ch.src_block);
            check_field("dst_block", want.dst_block, rsp_ch.dst_block);
            check_field("entry_index", 32'(want.entry_index), 32'(rsp_ch.entry_index));
            check_field("entry_count", 32'(want.entry_count), 32'(rsp_ch.entry_count));
            check_field("last", 32'(want.last), 32'(rsp_ch.last));
         end
      end
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
      rsp_ch.ready <= no_idle || ($urandom_range(0, 99) >= 37);
   end

   initial begin
      int budget;
      int phase;
      items_sent          = 0;
      no_idle             = 1'b0;
      reset               = 1'b1;
      csr_wr_en           = 1'b0;
      csr_index           = '0;
      csr_data            = '0;
      req_ch.valid        = 1'b0;
      req_ch.kind         = '0;
      req_ch.block_number = '0;
      cfg_log_start       = 32'd2;
      cfg_area            = 17;
      cfg_reserve         = 4;
      jnl_count           = 0;
      open_ops            = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_csr) begin
            settle_block();
            write_register(directed_rows[i].code, directed_rows[i].value);
         end else begin
            send_request(directed_rows[i].code, directed_rows[i].value,
                         directed_rows[i].typed, directed_rows[i].status,
                         directed_rows[i].count);
         end
      end

      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         program_phase(phase);
         if (phase == SATURATION_PHASE) begin
            // With nothing reserved per operation, begins pile up to the ceiling.
            no_idle = 1'b1;
            repeat (OPS_CEILING + 1)
               send_request(KIND_BEGIN, $urandom(), 1'b0, ST_GRANTED, '0);
            repeat ($urandom_range(1, 4))
               send_request(KIND_WRITE, $urandom(), 1'b0, ST_GRANTED, '0);
            repeat (OPS_CEILING + 1)
               send_request(KIND_END, $urandom(), 1'b0, ST_GRANTED, '0);
            no_idle = 1'b0;
         end else begin
            budget = $urandom_range(12, 24);
            repeat (budget)
               send_random_request();
            while (open_ops > 0)
               send_request(KIND_END, $urandom(), 1'b0, ST_GRANTED, '0);
         end
         phase++;
      end

      req_ch.valid <= 1'b0;
      while (journal_beats_due.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// File: sim.f
hw/rtl/jtt_pkg.sv
hw/rtl/jtt_intf.sv
hw/rtl/jtt_table.sv
hw/rtl/jtt_seq.sv
hw/rtl/journal_transaction_tracker.sv
tb/journal_transaction_tracker_tb.sv
